[rtl/core/cgs_pkg.sv]
// shared types and constants for the confidence gate smoother
// no dependencies; used by every module of the block
package cgs_pkg;

    localparam int CONF_W      = 16;
    localparam int GAIN_W      = 16;
    localparam int LEVEL_W     = 24;
    localparam int RUN_W       = 8;
    localparam int HOLD_W      = 16;
    localparam int COEF_W      = 16;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 4;

    // gate modes, code 3 falls back to automatic
    localparam logic [1:0] MODE_AUTO = 2'd0;
    localparam logic [1:0] MODE_OPEN = 2'd1;
    localparam logic [1:0] MODE_DUCK = 2'd2;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_GATE_MODE    = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OPEN_THRESH  = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CLOSE_THRESH = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_OPEN_FRAMES  = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CLOSE_FRAMES = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_FRAMES  = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_DUCK_LEVEL   = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SMOOTH_COEFS = 4'd7;

    // reset values
    localparam logic [1:0]               GATE_MODE_RST    = MODE_AUTO;
    localparam logic [CONF_W-1:0]        OPEN_THRESH_RST  = 16'd19661;
    localparam logic [CONF_W-1:0]        CLOSE_THRESH_RST = 16'd13107;
    localparam logic [RUN_W-1:0]         OPEN_FRAMES_RST  = 8'd3;
    localparam logic [RUN_W-1:0]         CLOSE_FRAMES_RST = 8'd3;
    localparam logic [HOLD_W-1:0]        HOLD_FRAMES_RST  = 16'd0;
    localparam logic signed [GAIN_W-1:0] DUCK_LEVEL_RST   = -16'sd3072;
    localparam logic [CFG_DATA_W-1:0]    SMOOTH_COEFS_RST = 32'hE666_8000;

    localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

    typedef struct packed {
        logic [1:0]               gate_mode;
        logic [CONF_W-1:0]        open_threshold;
        logic [CONF_W-1:0]        close_threshold;
        logic [RUN_W-1:0]         open_frames;
        logic [RUN_W-1:0]         close_frames;
        logic [HOLD_W-1:0]        hold_frames;
        logic signed [GAIN_W-1:0] duck_level;
        logic [COEF_W-1:0]        release_coef;
        logic [COEF_W-1:0]        attack_coef;
    } cfg_t;

endpackage

[rtl/core/cgs_conf_if.sv]
// valid/ready channel that carries one confidence value per transaction
// no dependencies
interface cgs_conf_if;
    logic        valid;
    logic        ready;
    logic [15:0] confidence;

    modport source (output valid, output confidence, input ready);
    modport sink (input valid, input confidence, output ready);
endinterface

[rtl/core/cgs_gain_if.sv]
// valid/ready channel that carries one smoothed gain per transaction
// no dependencies
interface cgs_gain_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] gain_level;

    modport source (output valid, output gain_level, input ready);
    modport sink (input valid, input gain_level, output ready);
endinterface

[rtl/core/cgs_cfg_regs.sv]
// configuration register file of the gate smoother
// depends on cgs_pkg
module cgs_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [cgs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [cgs_pkg::CFG_DATA_W-1:0]   cfg_data,
    output cgs_pkg::cfg_t                    cfg
);
    import cgs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_GATE_MODE:    cfg_next.gate_mode       = cfg_data[1:0];
                REG_OPEN_THRESH:  cfg_next.open_threshold  = cfg_data[CONF_W-1:0];
                REG_CLOSE_THRESH: cfg_next.close_threshold = cfg_data[CONF_W-1:0];
                REG_OPEN_FRAMES:  cfg_next.open_frames     = cfg_data[RUN_W-1:0];
                REG_CLOSE_FRAMES: cfg_next.close_frames    = cfg_data[RUN_W-1:0];
                REG_HOLD_FRAMES:  cfg_next.hold_frames     = cfg_data[HOLD_W-1:0];
                REG_DUCK_LEVEL:   cfg_next.duck_level      = $signed(cfg_data[GAIN_W-1:0]);
                REG_SMOOTH_COEFS:
                begin
                    cfg_next.attack_coef  = cfg_data[COEF_W-1:0];
                    cfg_next.release_coef = cfg_data[2*COEF_W-1:COEF_W];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gate_mode       <= GATE_MODE_RST;
            cfg_reg.open_threshold  <= OPEN_THRESH_RST;
            cfg_reg.close_threshold <= CLOSE_THRESH_RST;
            cfg_reg.open_frames     <= OPEN_FRAMES_RST;
            cfg_reg.close_frames    <= CLOSE_FRAMES_RST;
            cfg_reg.hold_frames     <= HOLD_FRAMES_RST;
            cfg_reg.duck_level      <= DUCK_LEVEL_RST;
            cfg_reg.attack_coef     <= SMOOTH_COEFS_RST[COEF_W-1:0];
            cfg_reg.release_coef    <= SMOOTH_COEFS_RST[2*COEF_W-1:COEF_W];
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/core/cgs_gate_ctrl.sv]
// hysteresis run counters, hold countdown and gate target decision
// depends on cgs_pkg
module cgs_gate_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic [cgs_pkg::CONF_W-1:0]  confidence,
    input  cgs_pkg::cfg_t               cfg,
    output logic                        target_open_next
);
    import cgs_pkg::*;

    logic [RUN_W-1:0]  high_run_reg, high_run_next;
    logic [RUN_W-1:0]  low_run_reg, low_run_next;
    logic [HOLD_W-1:0] hold_left_reg, hold_left_next;
    logic              target_open_reg;
    logic [HOLD_W-1:0] hold_mid;
    logic              is_auto;
    logic              open_hit;

    always_comb
    begin
        is_auto         = !(cfg.gate_mode == MODE_OPEN || cfg.gate_mode == MODE_DUCK);
        high_run_next   = high_run_reg;
        low_run_next    = low_run_reg;
        hold_mid        = hold_left_reg;
        target_open_next = target_open_reg;
        open_hit        = 1'b0;

        if (cfg.gate_mode == MODE_OPEN)
        begin
            target_open_next = 1'b1;
        end
        else if (cfg.gate_mode == MODE_DUCK)
        begin
            target_open_next = 1'b0;
        end

        if (is_auto)
        begin
            // high test wins when the two bands overlap
            if (confidence >= cfg.open_threshold)
            begin
                if (high_run_reg != RUN_MAX)
                    high_run_next = high_run_reg + 1'b1;
                low_run_next = '0;
            end
            else if (confidence <= cfg.close_threshold)
            begin
                if (low_run_reg != RUN_MAX)
                    low_run_next = low_run_reg + 1'b1;
                high_run_next = '0;
            end
            else
            begin
                // middle band: only the high run restarts
                high_run_next = '0;
            end

            open_hit = high_run_next >= cfg.open_frames;
            if (open_hit)
            begin
                target_open_next = 1'b1;
                hold_mid         = cfg.hold_frames;
            end
            else if (low_run_next >= cfg.close_frames && hold_left_reg == '0)
            begin
                target_open_next = 1'b0;
            end
        end

        hold_left_next = (hold_mid != '0) ? hold_mid - 1'b1 : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_run_reg    <= '0;
            low_run_reg     <= '0;
            hold_left_reg   <= '0;
            target_open_reg <= 1'b0;
        end
        else if (advance)
        begin
            high_run_reg    <= high_run_next;
            low_run_reg     <= low_run_next;
            hold_left_reg   <= hold_left_next;
            target_open_reg <= target_open_next;
        end
    end

endmodule

[rtl/core/cgs_smoother.sv]
// one-pole attack/release smoothing of the gain level with clamp
// depends on cgs_pkg
module cgs_smoother (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               advance,
    input  logic                               target_open,
    input  cgs_pkg::cfg_t                      cfg,
    output logic signed [cgs_pkg::GAIN_W-1:0]  gain_next
);
    import cgs_pkg::*;

    localparam int DIFF_W = LEVEL_W + 1;
    localparam int SUM_W  = LEVEL_W + 2;
    localparam int PROD_W = LEVEL_W + COEF_W;
    localparam int FRAC_W = LEVEL_W - GAIN_W;

    logic signed [LEVEL_W-1:0] level_reg, level_next;
    logic signed [GAIN_W-1:0]  eff_duck;
    logic signed [LEVEL_W-1:0] low_lim;
    logic signed [LEVEL_W-1:0] target;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [DIFF_W-1:0]  neg_diff;
    logic                      above;
    logic [LEVEL_W-1:0]        mag_in;
    logic [COEF_W-1:0]         coef;
    logic [PROD_W-1:0]         prod;
    logic [LEVEL_W-1:0]        mag;
    logic signed [SUM_W-1:0]   step;
    logic signed [SUM_W-1:0]   sum;
    logic signed [SUM_W-1:0]   low_ext;

    always_comb
    begin
        // a positive duck level acts as 0 dB
        eff_duck = cfg.duck_level[GAIN_W-1] ? cfg.duck_level : '0;
        low_lim  = $signed({eff_duck, {FRAC_W{1'b0}}});
        target   = target_open ? '0 : low_lim;
        diff     = $signed({level_reg[LEVEL_W-1], level_reg})
                 - $signed({target[LEVEL_W-1], target});
        neg_diff = -diff;
        above    = !diff[DIFF_W-1] && (diff != '0);
        mag_in   = above ? diff[LEVEL_W-1:0] : neg_diff[LEVEL_W-1:0];
        coef     = above ? cfg.attack_coef : cfg.release_coef;
        prod     = mag_in * coef;
        // magnitude truncates toward zero so the level always settles
        mag      = prod[PROD_W-1:COEF_W];
        step     = above ? $signed({2'b00, mag}) : -$signed({2'b00, mag});
        sum      = $signed({{2{target[LEVEL_W-1]}}, target}) + step;
        low_ext  = $signed({{2{low_lim[LEVEL_W-1]}}, low_lim});

        if (sum < low_ext)
            level_next = low_lim;
        else if (sum > $signed({SUM_W{1'b0}}))
            level_next = '0;
        else
            level_next = sum[LEVEL_W-1:0];

        gain_next = level_next[LEVEL_W-1:FRAC_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            level_reg <= $signed({DUCK_LEVEL_RST, {FRAC_W{1'b0}}});
        else if (advance)
            level_reg <= level_next;
    end

endmodule

[rtl/core/confidence_gate_smoother.sv]
// top level of the confidence gate smoother: pipeline registers and handshake
// depends on cgs_pkg, cgs_conf_if, cgs_gain_if, cgs_cfg_regs, cgs_gate_ctrl,
// cgs_smoother
//
// Takes one voice confidence (Q1.15) per transaction and returns one smoothed
// gain in 1/256 dB per transaction, either heading to 0 dB or to the duck
// level. Each item passes an input register, then the gate decision and a
// 24x16 multiply for the smoothing step into the result register; a new item
// is accepted every cycle while the result does not stall. The gate decision
// feeds the smoothing step combinationally; both states update on advance.
// A stalled result holds the pipeline, and the input side keeps accepting
// while the input register is empty or the result register is free or being
// drained. Registers are written through cfg_we/cfg_index/cfg_data; the user
// must write them only while no item is in flight (the block does not enforce
// it); indexes above 7 are ignored. Register writes never touch the gate state.
module confidence_gate_smoother (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [cgs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [cgs_pkg::CFG_DATA_W-1:0]   cfg_data,
    cgs_conf_if.sink                         conf_ch,
    cgs_gain_if.source                       gain_ch
);
    import cgs_pkg::*;

    cfg_t                      cfg;
    logic                      s1_valid_reg, s1_valid_next;
    logic [CONF_W-1:0]         s1_conf_reg;
    logic                      out_valid_reg, out_valid_next;
    logic signed [GAIN_W-1:0]  out_gain_reg;
    logic signed [GAIN_W-1:0]  gain_next;
    logic                      advance;
    logic                      in_take;
    logic                      target_open_next;

    assign advance       = s1_valid_reg && (!out_valid_reg || gain_ch.ready);
    assign conf_ch.ready = !s1_valid_reg || advance;
    assign in_take       = conf_ch.valid && conf_ch.ready;

    always_comb
    begin
        s1_valid_next = in_take ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
        out_valid_next = advance ? 1'b1 : (gain_ch.ready ? 1'b0 : out_valid_reg);
    end

    cgs_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cgs_gate_ctrl u_gate_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .advance          (advance),
        .confidence       (s1_conf_reg),
        .cfg              (cfg),
        .target_open_next (target_open_next)
    );

    cgs_smoother u_smoother (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .target_open (target_open_next),
        .cfg         (cfg),
        .gain_next   (gain_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_conf_reg <= conf_ch.confidence;
        if (advance)
            out_gain_reg <= gain_next;
    end

    assign gain_ch.valid      = out_valid_reg;
    assign gain_ch.gain_level = out_gain_reg;

`ifndef SYNTHESIS
    // the clamp keeps every delivered gain at or below 0 dB
    a_gain_not_positive: assert property (@(posedge clk) disable iff (!rst_n)
        gain_ch.valid |-> !(gain_ch.gain_level > 16'sd0))
        else $error("gain above 0 dB delivered");

    // an item in the input register must not vanish while the result stalls
    a_stall_keeps_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !gain_ch.ready) |=> s1_valid_reg)
        else $error("input register item lost during stall");

    // the input side only blocks when the input register holds an item
    a_ready_low_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        !conf_ch.ready |-> s1_valid_reg)
        else $error("input blocked with empty input register");

    // every advance produces a result in the next cycle
    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> gain_ch.valid)
        else $error("advanced item did not reach the result register");
`endif

endmodule
